/* sv/lmfdd_pkg.sv */
package lmfdd_pkg;

	localparam logic [3:0] MAX_CHAIN = 4'd8;
	localparam logic [15:0] WORD_NOP = 16'h0000;
	localparam logic [2:0] INIT_LAST = 3'd4;
	localparam logic [2:0] ROW_LAST = 3'd7;

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_FLUSH = 2'd1,
		OP_CLEAR = 2'd2,
		OP_INIT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_CHAIN_LENGTH   = 2'd0,
		REG_CHAIN_POSITION = 2'd1,
		REG_INTENSITY      = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LOAD,
		ST_SHIFT,
		ST_ADV,
		ST_FIN
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] pixel_x;
		logic [2:0] pixel_y;
	} cmd_t;

	typedef struct packed {
		logic [15:0] shift_word;
		logic        latch_after;
		logic        last;
	} result_t;

	// Setup sequence: display test off, normal operation, no decode,
	// scan all digits, intensity.
	function automatic logic [15:0] init_word(input logic [2:0] grp,
			input logic [3:0] intensity);
		logic [15:0] w;
		unique case (grp)
			3'd0:    w = 16'h0F00;
			3'd1:    w = 16'h0C01;
			3'd2:    w = 16'h0900;
			3'd3:    w = 16'h0B07;
			3'd4:    w = {12'h0A0, intensity};
			default: w = WORD_NOP;
		endcase
		return w;
	endfunction

endpackage

/* sv/led_matrix_frame_diff_driver.sv */
// Frame-difference driver for one 8x8 matrix in a chain of serial display drivers.
// Set pixel leaves busy low. Flush, clear and initialize raise busy; every emitted
// word passes a load step, the one-bit-per-clock word shifter and an advance step
// with strobe high, and a flush also scans each row it reaches and ends in a closing
// step. Each word is valid on result while strobe is high, which is a single cycle;
// the receiver cannot hold it off, so it must take every strobe. Configuration
// writes are taken while busy is low.
module led_matrix_frame_diff_driver (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lmfdd_pkg::cmd_t     cmd,
	output logic                strobe,
	output lmfdd_pkg::result_t  result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [3:0]          cfg_data
);

	lmfdd_pkg::state_t state_q, state_d;

	logic [3:0]  chain_length_q, chain_position_q, intensity_q;
	logic [63:0] frame_q, shown_q;
	logic [7:0]  chg_q, chg_d;
	logic [2:0]  idx_q, w_q;
	logic        flush_q;
	logic [15:0] sh_q;
	logic [3:0]  cnt_q;
	logic        strobe_q;
	lmfdd_pkg::result_t res_q;

	logic [3:0]  len, pos, pre;
	logic [2:0]  last_w;
	logic        word_done;
	logic [7:0]  row_byte;
	logic [7:0]  row_addr;
	logic [15:0] word_d;
	logic        latch_d, last_d;

	// Clamp chain length and position.
	always_comb begin
		if (chain_length_q == 4'd0)
			len = 4'd1;
		else if (chain_length_q > lmfdd_pkg::MAX_CHAIN)
			len = lmfdd_pkg::MAX_CHAIN;
		else
			len = chain_length_q;
		if (chain_position_q == 4'd0)
			pos = 4'd1;
		else if (chain_position_q > len)
			pos = len;
		else
			pos = chain_position_q;
		pre = len - pos;
	end

	assign last_w    = 3'(len - 4'd1);
	assign word_done = (w_q == last_w);

	always_comb begin
		for (int i = 0; i < 8; i++)
			chg_d[i] = (frame_q[8*i +: 8] != shown_q[8*i +: 8]);
	end

	assign row_byte = frame_q[{idx_q, 3'b000} +: 8];
	assign row_addr = 8'({1'b0, idx_q}) + 8'd1;

	always_comb begin
		if (flush_q)
			word_d = (w_q == 3'(pre)) ? {row_addr, row_byte} : lmfdd_pkg::WORD_NOP;
		else
			word_d = lmfdd_pkg::init_word(idx_q, intensity_q);
		latch_d = word_done;
		// Row bits are dropped as rows are taken, so an empty mask means no rows remain.
		last_d = word_done && (flush_q ? (chg_q == 8'd0) : (idx_q == lmfdd_pkg::INIT_LAST));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lmfdd_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		busy      = (state_q != lmfdd_pkg::ST_IDLE);
		cfg_ready = (state_q == lmfdd_pkg::ST_IDLE);
		unique case (state_q)
			lmfdd_pkg::ST_IDLE: begin
				if (start && cmd.op != lmfdd_pkg::OP_SET)
					state_d = (cmd.op == lmfdd_pkg::OP_INIT) ? lmfdd_pkg::ST_LOAD
						: lmfdd_pkg::ST_SCAN;
			end
			lmfdd_pkg::ST_SCAN: begin
				if (chg_q[idx_q])
					state_d = lmfdd_pkg::ST_LOAD;
				else if (idx_q == lmfdd_pkg::ROW_LAST)
					state_d = lmfdd_pkg::ST_FIN;
			end
			lmfdd_pkg::ST_LOAD:  state_d = lmfdd_pkg::ST_SHIFT;
			lmfdd_pkg::ST_SHIFT: begin
				if (cnt_q == 4'hF)
					state_d = lmfdd_pkg::ST_ADV;
			end
			lmfdd_pkg::ST_ADV: begin
				if (!word_done)
					state_d = lmfdd_pkg::ST_LOAD;
				else if (flush_q)
					// Stop once no changed rows remain or the last row is done.
					state_d = (idx_q == lmfdd_pkg::ROW_LAST || chg_q == 8'd0)
						? lmfdd_pkg::ST_FIN : lmfdd_pkg::ST_SCAN;
				else
					state_d = (idx_q == lmfdd_pkg::INIT_LAST) ? lmfdd_pkg::ST_FIN
						: lmfdd_pkg::ST_LOAD;
			end
			lmfdd_pkg::ST_FIN:   state_d = lmfdd_pkg::ST_IDLE;
			default:             state_d = lmfdd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			shown_q <= '1;
			chg_q   <= '0;
			idx_q   <= '0;
			w_q     <= '0;
			flush_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				lmfdd_pkg::ST_IDLE: begin
					if (start) begin
						idx_q <= '0;
						w_q   <= '0;
						unique case (cmd.op)
							lmfdd_pkg::OP_SET:
								frame_q[{cmd.pixel_y, cmd.pixel_x}] <= 1'b1;
							lmfdd_pkg::OP_FLUSH: begin
								chg_q   <= chg_d;
								flush_q <= 1'b1;
							end
							// Cleared frame: every row is marked changed and rewritten.
							lmfdd_pkg::OP_CLEAR: begin
								frame_q <= '0;
								chg_q   <= '1;
								flush_q <= 1'b1;
							end
							lmfdd_pkg::OP_INIT:
								flush_q <= 1'b0;
							default: ;
						endcase
					end
				end
				lmfdd_pkg::ST_SCAN: begin
					if (chg_q[idx_q]) begin
						chg_q[idx_q] <= 1'b0;
						w_q          <= '0;
					end else if (idx_q != lmfdd_pkg::ROW_LAST) begin
						idx_q <= idx_q + 3'd1;
					end
				end
				lmfdd_pkg::ST_SHIFT: cnt_q <= cnt_q + 4'd1;
				lmfdd_pkg::ST_ADV: begin
					if (!word_done) begin
						w_q <= w_q + 3'd1;
					end else begin
						w_q <= '0;
						if (!(flush_q ? (idx_q == lmfdd_pkg::ROW_LAST)
								: (idx_q == lmfdd_pkg::INIT_LAST)))
							idx_q <= idx_q + 3'd1;
					end
				end
				lmfdd_pkg::ST_FIN: begin
					if (flush_q) begin
						shown_q <= frame_q;
						frame_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Word shifter: one bit a cycle from sh_q into the result word.
	always_ff @(posedge clk) begin
		if (state_q == lmfdd_pkg::ST_LOAD) begin
			sh_q              <= word_d;
			res_q.latch_after <= latch_d;
			res_q.last        <= last_d;
		end else if (state_q == lmfdd_pkg::ST_SHIFT) begin
			sh_q             <= {sh_q[14:0], 1'b0};
			res_q.shift_word <= {res_q.shift_word[14:0], sh_q[15]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= (state_q == lmfdd_pkg::ST_SHIFT) && (cnt_q == 4'hF);
	end

	assign strobe = strobe_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_length_q   <= 4'd1;
			chain_position_q <= 4'd1;
			intensity_q      <= 4'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lmfdd_pkg::REG_CHAIN_LENGTH:   chain_length_q   <= cfg_data;
				lmfdd_pkg::REG_CHAIN_POSITION: chain_position_q <= cfg_data;
				lmfdd_pkg::REG_INTENSITY:      intensity_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	a_strobe_in_adv: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> state_q == lmfdd_pkg::ST_ADV)
		else $error("strobe outside advance state");

	a_last_ends_op: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |=> state_q == lmfdd_pkg::ST_FIN)
		else $error("sequence continued after last word");

	a_last_latches: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |-> result.latch_after)
		else $error("last word without latch");

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != lmfdd_pkg::ST_SHIFT) |-> cnt_q == 4'd0)
		else $error("bit counter not parked outside shift");

	a_no_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cfg_ready)
		else $error("configuration open while busy");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_REPORTS = 10;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	lmfdd_pkg::cmd_t cmd;
	logic strobe;
	lmfdd_pkg::result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [3:0] cfg_data;

	led_matrix_frame_diff_driver DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.strobe(strobe),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predicted display state and register copies
	logic [63:0] frame_q;
	logic [63:0] shown_q;
	logic [3:0] chain_len_q;
	logic [3:0] chain_pos_q;
	logic [3:0] intensity_q;

	lmfdd_pkg::result_t word_batch[$];
	lmfdd_pkg::result_t expected_words[$];

	int cycle_count;
	int items_sent;
	int words_checked;
	int mismatches;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected",
				cycle_count, expected_words.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Word checker: every strobe is a transaction the receiver must take
	always @(posedge clk) begin
		lmfdd_pkg::result_t want;
		if (arst_n && strobe) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected word %h latch %b last %b",
						result.shift_word, result.latch_after, result.last);
			end else begin
				want = expected_words.pop_front();
				words_checked++;
				if (result.shift_word !== want.shift_word ||
						result.latch_after !== want.latch_after ||
						result.last !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"mismatch: expected word %h latch %b last %b, ",
							"got word %h latch %b last %b"},
							want.shift_word, want.latch_after, want.last,
							result.shift_word, result.latch_after, result.last);
				end
			end
		end
	end

	function automatic lmfdd_pkg::cmd_t make_cmd(input lmfdd_pkg::op_t op,
			input logic [2:0] x, input logic [2:0] y);
		lmfdd_pkg::cmd_t c;
		c.op = op;
		c.pixel_x = x;
		c.pixel_y = y;
		return c;
	endfunction

	task automatic stage_word(input logic [15:0] w, input logic latch);
		lmfdd_pkg::result_t r;
		r.shift_word = w;
		r.latch_after = latch;
		r.last = 1'b0;
		word_batch.push_back(r);
	endtask

	task automatic refresh_rows(input logic [3:0] len, input logic [3:0] pos);
		for (int i = 0; i < 8; i++) begin
			if (frame_q[8*i +: 8] != shown_q[8*i +: 8]) begin
				repeat (len - pos) stage_word(lmfdd_pkg::WORD_NOP, 1'b0);
				stage_word({4'd0, 4'(i + 1), frame_q[8*i +: 8]}, pos == 4'd1);
				for (int j = 1; j < pos; j++)
					stage_word(lmfdd_pkg::WORD_NOP, j == pos - 1);
			end
		end
		shown_q = frame_q;
		frame_q = '0;
	endtask

	task automatic predict_words(input lmfdd_pkg::cmd_t c);
		logic [3:0] len;
		logic [3:0] pos;
		logic [15:0] w;
		lmfdd_pkg::result_t r;
		len = chain_len_q;
		if (len == 4'd0)
			len = 4'd1;
		if (len > lmfdd_pkg::MAX_CHAIN)
			len = lmfdd_pkg::MAX_CHAIN;
		pos = chain_pos_q;
		if (pos == 4'd0)
			pos = 4'd1;
		if (pos > len)
			pos = len;
		case (c.op)
			lmfdd_pkg::OP_SET: begin
				frame_q[{c.pixel_y, c.pixel_x}] = 1'b1;
			end
			lmfdd_pkg::OP_FLUSH: begin
				refresh_rows(len, pos);
			end
			lmfdd_pkg::OP_CLEAR: begin
				frame_q = '0;
				shown_q = '1;
				refresh_rows(len, pos);
			end
			lmfdd_pkg::OP_INIT: begin
				for (int g = 0; g < 5; g++) begin
					case (g)
						0: w = 16'h0F00;
						1: w = 16'h0C01;
						2: w = 16'h0900;
						3: w = 16'h0B07;
						default: w = {12'h0A0, intensity_q};
					endcase
					for (int k = 1; k <= len; k++)
						stage_word(w, k == len);
				end
			end
			default: begin
			end
		endcase
		for (int k = 0; k < word_batch.size(); k++) begin
			r = word_batch[k];
			r.last = (k == word_batch.size() - 1);
			expected_words.push_back(r);
		end
		word_batch.delete();
	endtask

	// Hold start high until the block takes the transaction
	task automatic send_cmd(input lmfdd_pkg::cmd_t c);
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_words(c);
		items_sent++;
	endtask

	task automatic hold_off(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Wait until every predicted word is out and the block is back to idle
	task automatic drain();
		start <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [3:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			lmfdd_pkg::REG_CHAIN_LENGTH: chain_len_q = data;
			lmfdd_pkg::REG_CHAIN_POSITION: chain_pos_q = data;
			lmfdd_pkg::REG_INTENSITY: intensity_q = data;
			default: begin
			end
		endcase
	endtask

	task automatic test_power_up_refresh();
		// shown frame starts all ones, so an empty flush rewrites every row
		send_cmd(make_cmd(lmfdd_pkg::OP_FLUSH, 3'd0, 3'd0));
		send_cmd(make_cmd(lmfdd_pkg::OP_FLUSH, 3'd7, 3'd7));
	endtask

	task automatic test_pixel_corners();
		send_cmd(make_cmd(lmfdd_pkg::OP_SET, 3'd0, 3'd0));
		send_cmd(make_cmd(lmfdd_pkg::OP_SET, 3'd7, 3'd0));
		send_cmd(make_cmd(lmfdd_pkg::OP_SET, 3'd0, 3'd7));
		send_cmd(make_cmd(lmfdd_pkg::OP_SET, 3'd7, 3'd7));
		send_cmd(make_cmd(lmfdd_pkg::OP_SET, 3'd3, 3'd4));
		send_cmd(make_cmd(lmfdd_pkg::OP_SET, 3'd3, 3'd4));
		send_cmd(make_cmd(lmfdd_pkg::OP_FLUSH, 3'd5, 3'd2));
		// rows lit last time go dark now
		send_cmd(make_cmd(lmfdd_pkg::OP_FLUSH, 3'd0, 3'd0));
	endtask

	task automatic test_initialize();
		send_cmd(make_cmd(lmfdd_pkg::OP_INIT, 3'd0, 3'd0));
	endtask

	task automatic test_long_chain();
		write_reg(lmfdd_pkg::REG_CHAIN_LENGTH, 4'd8);
		write_reg(lmfdd_pkg::REG_CHAIN_POSITION, 4'd8);
		write_reg(lmfdd_pkg::REG_INTENSITY, 4'd15);
		send_cmd(make_cmd(lmfdd_pkg::OP_INIT, 3'd7, 3'd7));
		send_cmd(make_cmd(lmfdd_pkg::OP_SET, 3'd5, 3'd2));
		send_cmd(make_cmd(lmfdd_pkg::OP_FLUSH, 3'd0, 3'd0));
		send_cmd(make_cmd(lmfdd_pkg::OP_CLEAR, 3'd7, 3'd7));
	endtask

	task automatic test_chain_clamping();
		write_reg(lmfdd_pkg::REG_CHAIN_LENGTH, 4'd0);
		write_reg(lmfdd_pkg::REG_CHAIN_POSITION, 4'd0);
		send_cmd(make_cmd(lmfdd_pkg::OP_SET, 3'd1, 3'd1));
		send_cmd(make_cmd(lmfdd_pkg::OP_FLUSH, 3'd0, 3'd0));
		write_reg(lmfdd_pkg::REG_CHAIN_LENGTH, 4'd15);
		write_reg(lmfdd_pkg::REG_CHAIN_POSITION, 4'd1);
		send_cmd(make_cmd(lmfdd_pkg::OP_SET, 3'd6, 3'd6));
		send_cmd(make_cmd(lmfdd_pkg::OP_FLUSH, 3'd0, 3'd0));
		write_reg(lmfdd_pkg::REG_CHAIN_POSITION, 4'd15);
		send_cmd(make_cmd(lmfdd_pkg::OP_CLEAR, 3'd2, 3'd5));
		write_reg(lmfdd_pkg::REG_CHAIN_LENGTH, 4'd3);
		write_reg(lmfdd_pkg::REG_CHAIN_POSITION, 4'd2);
		write_reg(lmfdd_pkg::REG_INTENSITY, 4'd9);
		// writes to the unused index must leave every register alone
		write_reg(REG_UNUSED, 4'hF);
		send_cmd(make_cmd(lmfdd_pkg::OP_INIT, 3'd0, 3'd0));
		send_cmd(make_cmd(lmfdd_pkg::OP_SET, 3'd4, 3'd0));
		send_cmd(make_cmd(lmfdd_pkg::OP_FLUSH, 3'd0, 3'd0));
	endtask

	task automatic test_random_traffic(input int idle_pct, input int count);
		int sent;
		int pixels;
		int pick;
		sent = 0;
		while (sent < count) begin
			if (sent % 30 == 0) begin
				// mostly short chains keep the long refreshes rare
				if ($urandom_range(0, 99) < 70)
					write_reg(lmfdd_pkg::REG_CHAIN_LENGTH, 4'($urandom_range(1, 3)));
				else
					write_reg(lmfdd_pkg::REG_CHAIN_LENGTH, 4'($urandom_range(0, 15)));
				write_reg(lmfdd_pkg::REG_CHAIN_POSITION, 4'($urandom_range(0, 15)));
				write_reg(lmfdd_pkg::REG_INTENSITY, 4'($urandom_range(0, 15)));
			end
			pixels = $urandom_range(0, 6);
			for (int k = 0; k <= pixels; k++) begin
				while ($urandom_range(0, 99) < idle_pct)
					hold_off(1);
				if (k < pixels) begin
					send_cmd(make_cmd(lmfdd_pkg::OP_SET, 3'($urandom_range(0, 7)),
						3'($urandom_range(0, 7))));
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 75)
						send_cmd(make_cmd(lmfdd_pkg::OP_FLUSH,
							3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))));
					else if (pick < 87)
						send_cmd(make_cmd(lmfdd_pkg::OP_CLEAR,
							3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))));
					else
						send_cmd(make_cmd(lmfdd_pkg::OP_INIT,
							3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))));
				end
				sent++;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_index = lmfdd_pkg::REG_CHAIN_LENGTH;
		cfg_data = 4'd0;
		frame_q = '0;
		shown_q = '1;
		chain_len_q = 4'd1;
		chain_pos_q = 4'd1;
		intensity_q = 4'd0;
		cycle_count = 0;
		items_sent = 0;
		words_checked = 0;
		mismatches = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_up_refresh();
		test_pixel_corners();
		test_initialize();
		test_long_chain();
		test_chain_clamping();
		test_random_traffic(13, 82);
		test_random_traffic(74, 82);
		test_random_traffic(0, 82);
		drain();

		$display("sent %0d commands (pixels, flushes, clears, setups) and checked %0d words",
			items_sent, words_checked);
		$display("chain lengths and positions covered in and out of range, %0d mismatches",
			mismatches);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
